// ----- rtl/bbox_zoom_fit_viewport_macros.svh -----
// Assertion macros shared by the viewport checker.
`ifndef BBOX_ZOOM_FIT_VIEWPORT_MACROS_SVH
`define BBOX_ZOOM_FIT_VIEWPORT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BZF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("viewport check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BZF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("viewport check failed");

`endif

// ----- rtl/bzf_pkg.sv -----
// Shared widths, request codes, register indexes and sequencer states.
package bzf_pkg;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned SSIZE_W   = 17;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned REQ_W     = 2;

  localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd800;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd600;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  localparam logic [REQ_W-1:0] REQ_INCLUDE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_UPDATE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MAP     = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_X_GO,
    ST_DIV_X_WAIT,
    ST_DIV_Y_GO,
    ST_DIV_Y_WAIT,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_S,
    ST_RESULT
  } state_e;

endpackage

// ----- rtl/bzf_if.sv -----
// Request and result channel interfaces of the viewport block.
interface bzf_req_if;
  import bzf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [SIZE_W-1:0]       obj_size;

  modport source (output valid, req_type, pos_x, pos_y, obj_size, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, obj_size, output ready);
endinterface

interface bzf_res_if;
  import bzf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] screen_x;
  logic signed [POS_W-1:0] screen_y;
  logic [SSIZE_W-1:0]      screen_size;

  modport source (output valid, screen_x, screen_y, screen_size, input ready);
  modport sink   (input valid, screen_x, screen_y, screen_size, output ready);
endinterface

// ----- rtl/bbox_zoom_fit_viewport.sv -----
// Top level of the auto-zoom viewport: sequencer, state and result register.
//
// Include requests grow the bounding box in the cycle of their transfer and
// leave the block ready in the next cycle. A map request steps through
// ST_MUL_X, ST_MUL_Y and ST_MUL_S to ST_RESULT, which loads the result
// register once it is empty or its result is taken; then the block is ready.
// One registered multiplier runs three passes (x offset, y offset, object
// size); a shared add-and-saturate step follows the x and y passes and the
// size pass only adds one. An update request runs the bit-serial divider
// once per axis, x then y, one quotient bit a cycle; an axis whose ratio
// saturates at one skips its iterations. The block takes one request at a
// time; a finished result waits in its own register, so the next request
// can be taken while the result has not yet been moved.
module bbox_zoom_fit_viewport #(
  parameter int unsigned MARGIN          = 100,
  parameter int unsigned COORD_WIDTH     = 32,
  parameter int unsigned RATIO_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bzf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bzf_pkg::DIM_W-1:0]     cfg_data_i,
  bzf_req_if.sink                       req_i,
  bzf_res_if.source                     res_o
);
  import bzf_pkg::*;

  localparam int unsigned RW  = RATIO_FRAC_BITS + 1;
  localparam int unsigned AW  = POS_W + 1;
  localparam int unsigned PW  = AW + RW + 1;
  localparam int unsigned AVW = DIM_W + 8;
  localparam int unsigned SPW = POS_W + 1;
  localparam int unsigned SW  = ((COORD_WIDTH > 36) ? COORD_WIDTH : 36) + 1;

  localparam logic [RW-1:0]          RATIO_ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};
  localparam logic [DIM_W:0]         MARG_D    = (DIM_W + 1)'(MARGIN);
  localparam logic [DIM_W:0]         MARG2_D   = (DIM_W + 1)'(2 * MARGIN);
  localparam logic signed [SW-1:0]   SAT_HI    = SW'({(COORD_WIDTH - 1){1'b1}});
  localparam logic signed [SW-1:0]   SAT_LO    = ~SAT_HI;

  function automatic logic signed [POS_W-1:0] ctr_init(logic [DIM_W-1:0] size);
    logic [DIM_W:0] d;
    d = {1'b0, size} - MARG_D;
    return POS_W'(signed'({d, 7'd0}));
  endfunction

  function automatic logic signed [POS_W-1:0] box_init(logic [DIM_W-1:0] size);
    return POS_W'({size, 8'd0});
  endfunction

  function automatic logic [AVW-1:0] avail_of(logic [DIM_W-1:0] size);
    logic [DIM_W:0] d;
    d = {1'b0, size} - MARG2_D;
    return ({1'b0, size} >= MARG2_D) ? {d[DIM_W-1:0], 8'd0} : '0;
  endfunction

  // Screen center plus margin: (size - M)*128 + M*256.
  function automatic logic signed [SW-1:0] off_of(logic [DIM_W-1:0] size);
    logic [DIM_W:0] s;
    s = {1'b0, size} + MARG_D;
    return SW'({s, 7'd0});
  endfunction

  state_e state_q, state_d;

  logic [DIM_W-1:0]        width_q, height_q;
  logic [DIM_W-1:0]        w_new, h_new;
  logic signed [POS_W-1:0] box_min_x_q, box_min_y_q, box_max_x_q, box_max_y_q;
  logic signed [POS_W-1:0] center_x_q, center_y_q;
  logic [RW-1:0]           ratio_q, rx_q;

  logic signed [POS_W-1:0] px_q, py_q;
  logic [SIZE_W-1:0]       sz_q;
  logic signed [POS_W-1:0] resx_q, resy_q;

  logic                    out_valid_q;
  logic signed [POS_W-1:0] out_x_q, out_y_q;
  logic [SSIZE_W-1:0]      out_s_q;

  logic                    in_fire;
  logic                    cfg_hit;
  logic                    upd_done;
  logic                    out_load;
  logic [SPW-1:0]          span_x, span_y;
  logic signed [POS_W-1:0] ctr_x_new, ctr_y_new;

  logic                    div_start;
  logic                    div_done;
  logic [AVW-1:0]          div_dvd;
  logic [SPW-1:0]          div_dvs;
  logic [RW-1:0]           div_quot;

  logic                    mul_en;
  logic signed [AW-1:0]    mul_a;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    prod_sh;
  logic signed [SW-1:0]    post_off;
  logic signed [SW-1:0]    post_sum;
  logic signed [SW-1:0]    post_sat;
  logic signed [POS_W-1:0] post_coord;
  logic [SSIZE_W-1:0]      size_new;

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign cfg_hit     = cfg_we_i && ((cfg_idx_i == CFG_WIDTH) || (cfg_idx_i == CFG_HEIGHT));
  assign w_new       = (cfg_idx_i == CFG_WIDTH)  ? cfg_data_i : width_q;
  assign h_new       = (cfg_idx_i == CFG_HEIGHT) ? cfg_data_i : height_q;
  assign upd_done    = (state_q == ST_DIV_Y_WAIT) && div_done;
  assign out_load    = (state_q == ST_RESULT) && (!out_valid_q || res_o.ready);

  // Spans never go negative: max stays at or above min.
  assign span_x    = SPW'(box_max_x_q) - SPW'(box_min_x_q);
  assign span_y    = SPW'(box_max_y_q) - SPW'(box_min_y_q);
  assign ctr_x_new = POS_W'(SPW'(box_min_x_q) + SPW'(span_x[SPW-1:1]));
  assign ctr_y_new = POS_W'(SPW'(box_min_y_q) + SPW'(span_y[SPW-1:1]));

  assign div_start = (state_q == ST_DIV_X_GO) || (state_q == ST_DIV_Y_GO);
  assign div_dvd   = (state_q == ST_DIV_Y_GO) ? avail_of(height_q) : avail_of(width_q);
  assign div_dvs   = (state_q == ST_DIV_Y_GO) ? span_y : span_x;

  bzf_div #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS),
    .DVD_W           (AVW),
    .DVS_W           (SPW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dvs_i   (div_dvs),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign mul_en = (state_q == ST_MUL_X) || (state_q == ST_MUL_Y) || (state_q == ST_MUL_S);

  always_comb begin
    case (state_q)
      ST_MUL_Y: mul_a = AW'(py_q) - AW'(center_y_q);
      ST_MUL_S: mul_a = AW'(sz_q);
      default:  mul_a = AW'(px_q) - AW'(center_x_q);
    endcase
  end

  bzf_mul #(
    .A_W (AW),
    .B_W (RW)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (ratio_q),
    .prod_o (prod)
  );

  // Floor the product, add the screen offset and saturate; the x pass finishes
  // while y multiplies, y while size multiplies.
  assign prod_sh    = prod >>> RATIO_FRAC_BITS;
  assign post_off   = (state_q == ST_MUL_S) ? off_of(height_q) : off_of(width_q);
  assign post_sum   = SW'(prod_sh) + post_off;
  assign post_sat   = (post_sum > SAT_HI) ? SAT_HI :
                      (post_sum < SAT_LO) ? SAT_LO : post_sum;
  assign post_coord = post_sat[POS_W-1:0];
  assign size_new   = SSIZE_W'(prod_sh[SIZE_W-1:0]) + SSIZE_W'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (req_i.req_type)
            REQ_UPDATE: state_d = ST_DIV_X_GO;
            REQ_MAP:    state_d = ST_MUL_X;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV_X_GO: state_d = ST_DIV_X_WAIT;
      ST_DIV_X_WAIT: begin
        if (div_done) state_d = ST_DIV_Y_GO;
      end
      ST_DIV_Y_GO: state_d = ST_DIV_Y_WAIT;
      ST_DIV_Y_WAIT: begin
        if (div_done) state_d = ST_IDLE;
      end
      ST_MUL_X: state_d = ST_MUL_Y;
      ST_MUL_Y: state_d = ST_MUL_S;
      ST_MUL_S: state_d = ST_RESULT;
      ST_RESULT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= RST_WIDTH;
      height_q    <= RST_HEIGHT;
      box_min_x_q <= '0;
      box_min_y_q <= '0;
      box_max_x_q <= box_init(RST_WIDTH);
      box_max_y_q <= box_init(RST_HEIGHT);
      center_x_q  <= ctr_init(RST_WIDTH);
      center_y_q  <= ctr_init(RST_HEIGHT);
      ratio_q     <= RATIO_ONE;
    end else if (cfg_hit) begin
      // A size write restarts the whole view from the new screen.
      width_q     <= w_new;
      height_q    <= h_new;
      box_min_x_q <= '0;
      box_min_y_q <= '0;
      box_max_x_q <= box_init(w_new);
      box_max_y_q <= box_init(h_new);
      center_x_q  <= ctr_init(w_new);
      center_y_q  <= ctr_init(h_new);
      ratio_q     <= RATIO_ONE;
    end else if (upd_done) begin
      ratio_q     <= (rx_q < div_quot) ? rx_q : div_quot;
      center_x_q  <= ctr_x_new;
      center_y_q  <= ctr_y_new;
      box_min_x_q <= ctr_x_new;
      box_max_x_q <= ctr_x_new;
      box_min_y_q <= ctr_y_new;
      box_max_y_q <= ctr_y_new;
    end else if (in_fire && (req_i.req_type == REQ_INCLUDE)) begin
      if (req_i.pos_x < box_min_x_q) box_min_x_q <= req_i.pos_x;
      if (req_i.pos_y < box_min_y_q) box_min_y_q <= req_i.pos_y;
      if (req_i.pos_x > box_max_x_q) box_max_x_q <= req_i.pos_x;
      if (req_i.pos_y > box_max_y_q) box_max_y_q <= req_i.pos_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px_q <= req_i.pos_x;
      py_q <= req_i.pos_y;
      sz_q <= req_i.obj_size;
    end
    if ((state_q == ST_DIV_X_WAIT) && div_done) begin
      rx_q <= div_quot;
    end
    if (state_q == ST_MUL_Y) begin
      resx_q <= post_coord;
    end
    if (state_q == ST_MUL_S) begin
      resy_q <= post_coord;
    end
    if (out_load) begin
      out_x_q <= resx_q;
      out_y_q <= resy_q;
      out_s_q <= size_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.screen_x    = out_x_q;
  assign res_o.screen_y    = out_y_q;
  assign res_o.screen_size = out_s_q;

endmodule

// ----- rtl/bzf_div.sv -----
// Bit-serial restoring divider for the saturated zoom ratio of one axis.
module bzf_div #(
  parameter int unsigned RATIO_FRAC_BITS = 16,
  parameter int unsigned DVD_W           = 21,
  parameter int unsigned DVS_W           = 33
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DVD_W-1:0]         dvd_i,
  input  logic [DVS_W-1:0]         dvs_i,
  output logic                     done_o,
  output logic [RATIO_FRAC_BITS:0] quot_o
);
  localparam int unsigned CNT_W = $clog2(RATIO_FRAC_BITS + 1);
  localparam logic [RATIO_FRAC_BITS:0] RATIO_ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(RATIO_FRAC_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

  logic                     busy_q;
  logic                     done_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [DVS_W-1:0]         rem_q;
  logic [DVS_W-1:0]         dvs_q;
  logic [RATIO_FRAC_BITS:0] quot_q;
  logic [DVS_W:0]           rem2;
  logic [DVS_W:0]           trial;
  logic                     fit;
  logic                     sat;

  // Dividend at or above divisor means the quotient would reach one: saturate now.
  assign sat   = (DVS_W'(dvd_i) >= dvs_i);
  assign rem2  = {rem_q, 1'b0};
  assign trial = rem2 - {1'b0, dvs_q};
  assign fit   = (rem2 >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (sat) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CNT_LOAD;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_LAST;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q  <= dvs_i;
      rem_q  <= DVS_W'(dvd_i);
      quot_q <= sat ? RATIO_ONE : '0;
    end else if (busy_q) begin
      rem_q  <= fit ? trial[DVS_W-1:0] : rem2[DVS_W-1:0];
      quot_q <= {quot_q[RATIO_FRAC_BITS-1:0], fit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/bzf_mul.sv -----
// Registered signed-by-unsigned multiplier shared by the map passes.
module bzf_mul #(
  parameter int unsigned A_W = 33,
  parameter int unsigned B_W = 17
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [A_W-1:0]     a_i,
  input  logic [B_W-1:0]            b_i,
  output logic signed [A_W+B_W:0]   prod_o
);
  logic signed [B_W:0]     b_s;
  logic signed [A_W+B_W:0] prod_q;

  assign b_s = {1'b0, b_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_s;
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/bzf_chk.sv -----
// Port-level checker for the viewport block and its bind to the top level.
`include "bbox_zoom_fit_viewport_macros.svh"

module bzf_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [bzf_pkg::REQ_W-1:0]     in_req_type_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [bzf_pkg::POS_W-1:0]     out_x_i,
  input logic [bzf_pkg::POS_W-1:0]     out_y_i,
  input logic [bzf_pkg::SSIZE_W-1:0]   out_size_i
);
  import bzf_pkg::*;

  // Hold a stalled result.
  `BZF_ASSERT_NXT(a_res_hold, out_valid_i && !out_ready_i,
                  out_valid_i && $stable(out_x_i) && $stable(out_y_i) && $stable(out_size_i))

  // A scaled size always carries the plus one.
  `BZF_ASSERT_IMP(a_size_nonzero, out_valid_i, out_size_i != '0)

  // A map transfer occupies the multiplier for the next cycles.
  `BZF_ASSERT_NXT(a_map_busy, in_valid_i && in_ready_i && (in_req_type_i == REQ_MAP),
                  !in_ready_i)

  // An include transfer finishes in its own cycle.
  `BZF_ASSERT_NXT(a_incl_ready, in_valid_i && in_ready_i && (in_req_type_i == REQ_INCLUDE),
                  in_ready_i)

endmodule

bind bbox_zoom_fit_viewport bzf_chk u_bzf_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .in_req_type_i (req_i.req_type),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .out_x_i       (res_o.screen_x),
  .out_y_i       (res_o.screen_y),
  .out_size_i    (res_o.screen_size)
);
